@@ design/command_line_tokenizer_macros.svh @@
// Assertion macros used by the tokenizer checker.
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CLT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define CLT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

@@ design/clt_pkg.sv @@
// Types, codes and constants of the command line tokenizer.
`timescale 1ns / 1ps

package clt_pkg;

   localparam int RunMaxDefault     = 255;
   localparam int QueueDepthDefault = 4;
   localparam int MaxRecs           = 4;

   localparam logic [7:0] CharBslash = 8'h5C;
   localparam logic [7:0] CharQuote  = 8'h22;
   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] CharTab    = 8'h09;

   typedef enum logic [2:0] {
      KIND_APPEND   = 3'd0,
      KIND_ARG_END  = 3'd1,
      KIND_DONE     = 3'd2,
      KIND_UNCLOSED = 3'd3,
      KIND_OVERFLOW = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_value;
      logic [7:0] repeat_count;
      logic       last_result;
   } rec_type;

   // All records caused by one input item.
   typedef struct packed {
      logic [2:0]            rec_count;
      rec_type [MaxRecs-1:0] recs;
   } bundle_type;

   function automatic rec_type mk_rec(kind_type kind, logic [7:0] value, logic [7:0] count);
      rec_type r;
      r.kind         = kind;
      r.byte_value   = value;
      r.repeat_count = count;
      r.last_result  = 1'b0;
      return r;
   endfunction

endpackage

@@ design/clt_front.sv @@
// Front end: takes bytes, tracks quoting and backslash runs, builds record bundles.
`timescale 1ns / 1ps

module clt_front import clt_pkg::*; #(
   parameter int RUN_MAX = RunMaxDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       item_accept,
   input  logic [7:0] char_byte,
   input  logic       end_of_command,
   output logic       bundle_valid,
   output bundle_type bundle
);

   localparam logic [7:0] RunLimit = 8'((RUN_MAX > 255) ? 255 : RUN_MAX);

   logic       quoting_ff, quoting_in;
   logic       open_ff, open_in;
   logic [7:0] run_ff, run_in;

   always_comb begin
      logic       handled;
      logic       overflow;
      logic       is_bs;
      logic       is_quote;
      logic       is_blank;
      logic [2:0] n;
      rec_type [MaxRecs-1:0] recs;

      quoting_in = quoting_ff;
      open_in    = open_ff;
      run_in     = run_ff;
      handled    = 1'b0;
      overflow   = 1'b0;
      n          = 3'd0;
      recs       = '0;
      is_bs      = (char_byte == CharBslash);
      is_quote   = (char_byte == CharQuote);
      is_blank   = (char_byte == CharSpace) || (char_byte == CharTab);

      // pending backslash run closed by a non-backslash byte
      if (run_ff != 8'd0 && !is_bs) begin
         if (is_quote) begin
            if (run_ff[7:1] != 7'd0) begin
               recs[n[1:0]] = mk_rec(KIND_APPEND, CharBslash, {1'b0, run_ff[7:1]});
               n = n + 3'd1;
            end
            if (!run_ff[0]) begin
               quoting_in = !quoting_in;
            end else begin
               recs[n[1:0]] = mk_rec(KIND_APPEND, CharQuote, 8'd1);
               n = n + 3'd1;
            end
            handled = 1'b1;
         end else begin
            recs[n[1:0]] = mk_rec(KIND_APPEND, CharBslash, run_ff);
            n = n + 3'd1;
         end
         open_in = 1'b1;
         run_in  = 8'd0;
      end

      if (!handled) begin
         if (!quoting_in && is_blank) begin
            if (open_in) begin
               recs[n[1:0]] = mk_rec(KIND_ARG_END, 8'd0, 8'd0);
               n = n + 3'd1;
               open_in = 1'b0;
            end
         end else if (is_bs) begin
            if (run_in >= RunLimit) begin
               overflow = 1'b1;
            end else begin
               run_in = run_in + 8'd1;
            end
         end else if (is_quote) begin
            quoting_in = !quoting_in;
            open_in    = 1'b1;
         end else begin
            recs[n[1:0]] = mk_rec(KIND_APPEND, char_byte, 8'd1);
            n = n + 3'd1;
            open_in = 1'b1;
         end
      end

      if (overflow) begin
         recs       = '0;
         recs[0]    = mk_rec(KIND_OVERFLOW, 8'd0, 8'd0);
         n          = 3'd1;
         quoting_in = 1'b0;
         open_in    = 1'b0;
         run_in     = 8'd0;
      end else if (end_of_command) begin
         if (run_in != 8'd0) begin
            recs[n[1:0]] = mk_rec(KIND_APPEND, CharBslash, run_in);
            n = n + 3'd1;
            open_in = 1'b1;
         end
         if (quoting_in) begin
            recs[n[1:0]] = mk_rec(KIND_UNCLOSED, 8'd0, 8'd0);
            n = n + 3'd1;
         end else begin
            if (open_in) begin
               recs[n[1:0]] = mk_rec(KIND_ARG_END, 8'd0, 8'd0);
               n = n + 3'd1;
            end
            recs[n[1:0]] = mk_rec(KIND_DONE, 8'd0, 8'd0);
            n = n + 3'd1;
         end
         quoting_in = 1'b0;
         open_in    = 1'b0;
         run_in     = 8'd0;
      end

      if (n != 3'd0) begin
         recs[2'(n - 3'd1)].last_result = 1'b1;
      end

      bundle.rec_count = n;
      bundle.recs      = recs;
      bundle_valid     = item_accept && (n != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quoting_ff <= 1'b0;
         open_ff    <= 1'b0;
         run_ff     <= 8'd0;
      end else if (item_accept) begin
         quoting_ff <= quoting_in;
         open_ff    <= open_in;
         run_ff     <= run_in;
      end
   end

endmodule

@@ design/clt_queue.sv @@
// Bundle queue between front and back ends.
`timescale 1ns / 1ps

module clt_queue import clt_pkg::*; #(
   parameter int DEPTH = QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  bundle_type push_data,
   output logic       push_ready,
   output logic       pop_valid,
   input  logic       pop_ready,
   output bundle_type pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
   localparam logic [CW-1:0] Full     = CW'(DEPTH);

   bundle_type        slots_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != Full);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/clt_back.sv @@
// Back end: sends the records of the head bundle one item per cycle while rsp_tready is high.
`timescale 1ns / 1ps

module clt_back import clt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  bundle_type head,
   output logic       head_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [2:0] rsp_tuser,
   output logic [15:0] rsp_tdata,
   output logic       rsp_tlast
);

   logic [1:0] sub_ff, sub_in;
   rec_type    cur;
   logic       send;
   logic       final_rec;

   assign cur        = head.recs[sub_ff];
   assign rsp_tvalid = head_valid;
   assign rsp_tuser  = cur.kind;
   assign rsp_tdata  = {cur.repeat_count, cur.byte_value};
   assign rsp_tlast  = cur.last_result;
   assign send       = head_valid && rsp_tready;
   assign final_rec  = ({1'b0, sub_ff} + 3'd1 == head.rec_count);
   assign head_pop   = send && final_rec;

   always_comb begin
      sub_in = sub_ff;
      if (send) begin
         sub_in = final_rec ? 2'd0 : sub_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 2'd0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

@@ design/command_line_tokenizer.sv @@
// Each accepted byte's bundle is registered in the queue; its results leave from the head.
// Throughput: one byte per cycle while the queue has room; a byte that causes several
// results sends them in turn; the bundle queue (QUEUE_DEPTH entries) absorbs such bursts.
// Output: one item per cycle while rsp_tready is high, set by the back-end serialiser.
// Reset: synchronous, clears quoting, argument and run state and empties the queue.
`timescale 1ns / 1ps

module command_line_tokenizer import clt_pkg::*; #(
   parameter int RUN_MAX     = RunMaxDefault,
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tlast,   // end_of_command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] byte_value, [15:8] repeat_count
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // last_result
);

   logic       item_accept;
   logic       push_valid;
   bundle_type push_data;
   logic       head_valid;
   bundle_type head;
   logic       head_pop;

   assign item_accept = req_tvalid && req_tready;

   clt_front #(.RUN_MAX(RUN_MAX)) u_front (
      .clock          (clock),
      .reset          (reset),
      .item_accept    (item_accept),
      .char_byte      (req_tdata),
      .end_of_command (req_tlast),
      .bundle_valid   (push_valid),
      .bundle         (push_data)
   );

   clt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (req_tready),
      .pop_valid  (head_valid),
      .pop_ready  (head_pop),
      .pop_data   (head)
   );

   clt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ design/clt_checker.sv @@
// Port-level checks on the tokenizer result stream, bound to the top level.
`timescale 1ns / 1ps
`include "command_line_tokenizer_macros.svh"

module clt_checker import clt_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic        is_append;
   logic        is_line_end;
   logic [19:0] rsp_bits;

   assign is_append   = (rsp_tuser == KIND_APPEND);
   assign is_line_end = (rsp_tuser == KIND_DONE) || (rsp_tuser == KIND_UNCLOSED)
                        || (rsp_tuser == KIND_OVERFLOW);
   assign rsp_bits    = {rsp_tlast, rsp_tuser, rsp_tdata};

   `CLT_ASSERT_NOW(kind_legal, rsp_tvalid, rsp_tuser <= KIND_OVERFLOW)
   `CLT_ASSERT_NOW(append_count_nonzero, rsp_tvalid && is_append, rsp_tdata[15:8] != 8'd0)
   `CLT_ASSERT_NOW(marker_data_zero, rsp_tvalid && !is_append, rsp_tdata == 16'd0)
   `CLT_ASSERT_NOW(line_end_is_last, rsp_tvalid && is_line_end, rsp_tlast)
   `CLT_ASSERT_NEXT(stall_holds, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_bits))

endmodule

bind command_line_tokenizer clt_checker u_checker (.*);

@@ tb/tb_command_line_tokenizer.sv @@
// Self-checking testbench for the command line tokenizer with its own result predictor.
`timescale 1ns / 1ps

module tb_command_line_tokenizer;
   import clt_pkg::*;

   localparam int ClockPeriod = 20;
   localparam int ResetCycles = 11;
   localparam int RunLimit    = (RunMaxDefault > 255) ? 255 : RunMaxDefault;
   localparam int RandomItems = 150;
   localparam int HoldCycles  = 300;
   localparam int QuietLimit  = 2000;
   localparam int SettleCycles = 10;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] char_byte
   logic        req_tlast  = 1'b0;    // end_of_command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] byte_value, [15:8] repeat_count
   logic [2:0]  rsp_tuser;            // [2:0] kind
   logic        rsp_tlast;            // last_result

   command_line_tokenizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // predictor state
   rec_type     expected_recs[$];
   logic        quote_open = 1'b0;
   logic        arg_open   = 1'b0;
   int unsigned slash_run  = 0;

   int mismatch_count  = 0;
   int results_checked = 0;
   int bytes_sent      = 0;
   int lines_sent      = 0;

   // sender burst control
   int burst_left = 0;
   bit steady     = 1'b0;

   // receiver control
   bit          hold_request = 1'b0;
   int          hold_left    = 0;
   logic [7:0]  stall_phase  = 8'd0;
   int          quiet_cycles = 0;

   function automatic rec_type make_rec(kind_type k, logic [7:0] v, logic [7:0] n);
      rec_type r;
      r.kind         = k;
      r.byte_value   = v;
      r.repeat_count = n;
      r.last_result  = 1'b0;
      return r;
   endfunction

   function automatic void clear_tokens();
      quote_open = 1'b0;
      arg_open   = 1'b0;
      slash_run  = 0;
   endfunction

   // Works out every result item one accepted byte causes.
   function automatic void tokenize_byte(input logic [7:0] ch, input logic eoc);
      rec_type produced[$];
      bit      handled;
      bit      overflowed;
      handled    = 1'b0;
      overflowed = 1'b0;
      if (slash_run != 0 && ch != CharBslash) begin
         if (ch == CharQuote) begin
            if (slash_run / 2 != 0)
               produced = {produced, make_rec(KIND_APPEND, CharBslash, 8'(slash_run / 2))};
            if (slash_run % 2 == 0)
               quote_open = !quote_open;
            else
               produced = {produced, make_rec(KIND_APPEND, CharQuote, 8'd1)};
            handled = 1'b1;
         end else begin
            produced = {produced, make_rec(KIND_APPEND, CharBslash, 8'(slash_run))};
         end
         arg_open  = 1'b1;
         slash_run = 0;
      end
      if (!handled) begin
         if (!quote_open && (ch == CharSpace || ch == CharTab)) begin
            if (arg_open) begin
               produced = {produced, make_rec(KIND_ARG_END, 8'd0, 8'd0)};
               arg_open = 1'b0;
            end
         end else if (ch == CharBslash) begin
            if (slash_run >= RunLimit) begin
               produced = {produced, make_rec(KIND_OVERFLOW, 8'd0, 8'd0)};
               clear_tokens();
               overflowed = 1'b1;
            end else begin
               slash_run++;
            end
         end else if (ch == CharQuote) begin
            quote_open = !quote_open;
            arg_open   = 1'b1;
         end else begin
            produced = {produced, make_rec(KIND_APPEND, ch, 8'd1)};
            arg_open = 1'b1;
         end
      end
      if (eoc && !overflowed) begin
         if (slash_run != 0) begin
            produced  = {produced, make_rec(KIND_APPEND, CharBslash, 8'(slash_run))};
            arg_open  = 1'b1;
            slash_run = 0;
         end
         if (quote_open) begin
            produced = {produced, make_rec(KIND_UNCLOSED, 8'd0, 8'd0)};
         end else begin
            if (arg_open)
               produced = {produced, make_rec(KIND_ARG_END, 8'd0, 8'd0)};
            produced = {produced, make_rec(KIND_DONE, 8'd0, 8'd0)};
         end
         clear_tokens();
      end
      if (produced.size() > 0)
         produced[produced.size() - 1].last_result = 1'b1;
      expected_recs = {expected_recs, produced};
   endfunction

   task automatic send_byte(input logic [7:0] ch, input logic eoc);
      int gap;
      @(negedge clock);
      if (!steady && burst_left == 0) begin
         gap        = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (burst_left > 0)
         burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= eoc;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      tokenize_byte(ch, eoc);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], i == s.len() - 1);
      lines_sent++;
   endtask

   task automatic send_line(input logic [7:0] line[$], input bit noisy);
      foreach (line[i])
         send_byte(line[i], (i == line.size() - 1) || (noisy && $urandom_range(0, 3) == 0));
      lines_sent++;
   endtask

   task automatic build_line(output logic [7:0] line[$], output bit noisy);
      int len;
      int pick;
      int run;
      line.delete();
      len   = $urandom_range(1, 24);
      noisy = ($urandom_range(0, 7) == 0);
      while (line.size() < len) begin
         pick = $urandom_range(0, 99);
         if (noisy || pick >= 80) begin
            line = {line, 8'($urandom_range(0, 255))};
         end else if (pick < 35) begin
            line = {line, 8'($urandom_range(8'h61, 8'h7A))};
         end else if (pick < 45) begin
            line = {line, CharSpace};
         end else if (pick < 50) begin
            line = {line, CharTab};
         end else if (pick < 62) begin
            line = {line, CharQuote};
         end else begin
            run = $urandom_range(1, 5);
            repeat (run) line = {line, CharBslash};
         end
      end
   endtask

   task automatic pause_sender();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      pause_sender();
      while (expected_recs.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_directed_rules();
      steady = 1'b1;
      send_text(" a\t\"b c\"");
      send_text("\\\\\"x\\\"");
      send_text("a\\b\\\\");
      send_text("\"\"");
      send_text(" ");
      send_text("\\\\\\\"");
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      lines_sent++;
      steady = 1'b0;
      wait_drained();
   endtask

   task automatic test_run_overflow();
      // quoted, longest legal run, then one backslash too many on the final byte
      send_byte(CharQuote, 1'b0);
      repeat (RunLimit) send_byte(CharBslash, 1'b0);
      send_byte(CharBslash, 1'b1);
      lines_sent++;
      wait_drained();
   endtask

   task automatic test_output_hold_off();
      logic [7:0] line[$];
      bit         noisy;
      int         start;
      start        = bytes_sent;
      hold_request = 1'b1;
      steady       = 1'b1;
      while (bytes_sent < start + 40) begin
         build_line(line, noisy);
         send_line(line, noisy);
      end
      steady = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_lines();
      logic [7:0] line[$];
      bit         noisy;
      int         start;
      start = bytes_sent;
      while (bytes_sent < start + RandomItems) begin
         steady = ($urandom_range(0, 3) == 0);
         build_line(line, noisy);
         send_line(line, noisy);
         if ($urandom_range(0, 9) == 0)
            wait_drained();
      end
      steady = 1'b0;
      wait_drained();
   endtask

   // receiver: rotating stall pattern, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HoldCycles;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         stall_phase = stall_phase + 8'd1;
         case (stall_phase[7:6])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= 1'($urandom_range(0, 1));
            2'd2: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= (stall_phase % 3 != 0);
         endcase
      end
   end

   always @(posedge clock) begin : check_result
      rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_recs.size() == 0) begin
            $display("%0t: unexpected item kind %0d data %h last %b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            want = expected_recs.pop_front();
            results_checked++;
            if (rsp_tuser !== want.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, want.kind, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[7:0] !== want.byte_value) begin
               $display("%0t: byte_value expected %h actual %h",
                        $time, want.byte_value, rsp_tdata[7:0]);
               mismatch_count++;
            end
            if (rsp_tdata[15:8] !== want.repeat_count) begin
               $display("%0t: repeat_count expected %0d actual %0d",
                        $time, want.repeat_count, rsp_tdata[15:8]);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last_result) begin
               $display("%0t: last_result expected %b actual %b",
                        $time, want.last_result, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("%0t: timeout, %0d items still expected", $time, expected_recs.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;
      test_directed_rules();
      test_run_overflow();
      test_output_hold_off();
      test_random_lines();
      repeat (SettleCycles) @(posedge clock);
      if (expected_recs.size() != 0) begin
         $display("%0t: %0d expected items never arrived", $time, expected_recs.size());
         mismatch_count++;
      end
      $display("Sent %0d bytes over %0d command lines (quotes, runs, overflow, unclosed).",
               bytes_sent, lines_sent);
      $display("Checked %0d result items under output stalls and a long hold-off.",
               results_checked);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
